### src/cnw_pkg.sv
// ============================================================================
// cnw_pkg
// Shared item types, phase codes, event codes and byte-matching functions
// for the cpio newc entry walker.
// ============================================================================
`default_nettype none

package cnw_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] entry_file_size;
        logic [31:0] entry_name_size;
        logic [15:0] files_seen;
    } event_item_t;

    typedef struct packed {
        logic        valid;
        event_item_t item;
    } cnw_res_t;

    localparam logic [1:0] EV_ENTRY = 2'd0;
    localparam logic [1:0] EV_END   = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_PAD1   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_PAD2   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [31:0] MAGIC_LEN = 32'd6;
    localparam logic [31:0] HDR_LEN   = 32'd110;
    localparam logic [31:0] FSZ_FIRST = 32'd54;
    localparam logic [31:0] FSZ_LAST  = 32'd61;
    localparam logic [31:0] NSZ_FIRST = 32'd94;
    localparam logic [31:0] NSZ_LAST  = 32'd101;
    localparam logic [31:0] TRL_LEN   = 32'd11;

    // Returns the digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = 8'h30;
            3'd1:    r = 8'h37;
            3'd2:    r = 8'h30;
            3'd3:    r = 8'h37;
            3'd4:    r = 8'h30;
            3'd5:    r = 8'h31;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] trailer_byte(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:    r = 8'h54;
            4'd1:    r = 8'h52;
            4'd2:    r = 8'h41;
            4'd3:    r = 8'h49;
            4'd4:    r = 8'h4C;
            4'd5:    r = 8'h45;
            4'd6:    r = 8'h52;
            4'd7:    r = 8'h21;
            4'd8:    r = 8'h21;
            4'd9:    r = 8'h21;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/cnw_parser.sv
// ============================================================================
// cnw_parser
// Input register and the per-byte parser state update.
// ============================================================================
`default_nettype none

module cnw_parser #(
    parameter int COUNT_WIDTH = cnw_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire cnw_pkg::byte_item_t byte_item,
    input  wire logic                res_ready,
    output cnw_pkg::cnw_res_t        res
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                item_valid_reg;
    cnw_pkg::byte_item_t item_reg;
    logic                advance;

    logic [2:0]             phase_reg, phase_next;
    logic [31:0]            count_reg, count_next;
    logic [31:0]            nsz_reg, nsz_next;
    logic [31:0]            fsz_reg, fsz_next;
    logic                   match_reg, match_next;
    logic [COUNT_WIDTH-1:0] entries_reg, entries_next;
    logic [1:0]             off_reg, off_next;

    logic       emit;
    logic       fin;
    logic       err;
    logic [1:0] kind;
    logic [4:0] hv;
    logic [7:0] b;

    assign advance    = item_valid_reg && res_ready;
    assign byte_stall = item_valid_reg && !res_ready;
    assign b          = item_reg.data_byte;
    assign hv         = cnw_pkg::hex_digit(b);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end
        else if (!byte_stall) begin
            item_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (byte_valid && !byte_stall) begin
            item_reg <= byte_item;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        nsz_next     = nsz_reg;
        fsz_next     = fsz_reg;
        match_next   = match_reg;
        entries_next = entries_reg;
        off_next     = off_reg;
        emit         = 1'b0;
        fin          = 1'b0;
        err          = 1'b0;
        kind         = cnw_pkg::EV_ENTRY;

        if (item_reg.restart) begin
            phase_next   = cnw_pkg::PH_MAGIC;
            count_next   = 32'd0;
            nsz_next     = 32'd0;
            fsz_next     = 32'd0;
            match_next   = 1'b1;
            entries_next = '0;
            off_next     = 2'd0;
        end

        if (phase_next < cnw_pkg::PH_DONE) begin
            off_next = off_next + 2'd1;
            case (phase_next)
                cnw_pkg::PH_MAGIC:
                begin
                    if (count_next == 32'd0) begin
                        nsz_next   = 32'd0;
                        fsz_next   = 32'd0;
                        match_next = 1'b1;
                    end
                    if (count_next >= cnw_pkg::MAGIC_LEN
                        || b != cnw_pkg::magic_byte(count_next[2:0])) begin
                        err = 1'b1;
                    end
                    else begin
                        count_next = count_next + 32'd1;
                        if (count_next == cnw_pkg::MAGIC_LEN) begin
                            phase_next = cnw_pkg::PH_HEADER;
                        end
                    end
                end
                cnw_pkg::PH_HEADER:
                begin
                    if (count_next >= cnw_pkg::FSZ_FIRST && count_next <= cnw_pkg::FSZ_LAST)
                    begin
                        if (!hv[4]) begin
                            err = 1'b1;
                        end
                        else begin
                            fsz_next = {fsz_next[27:0], hv[3:0]};
                        end
                    end
                    else if (count_next >= cnw_pkg::NSZ_FIRST
                             && count_next <= cnw_pkg::NSZ_LAST) begin
                        if (!hv[4]) begin
                            err = 1'b1;
                        end
                        else begin
                            nsz_next = {nsz_next[27:0], hv[3:0]};
                        end
                    end
                    if (!err) begin
                        count_next = count_next + 32'd1;
                        if (count_next >= cnw_pkg::HDR_LEN) begin
                            phase_next = cnw_pkg::PH_NAME;
                            count_next = 32'd0;
                            fin        = (nsz_next == 32'd0);
                        end
                    end
                end
                cnw_pkg::PH_NAME:
                begin
                    if (count_next < cnw_pkg::TRL_LEN
                        && b != cnw_pkg::trailer_byte(count_next[3:0])) begin
                        match_next = 1'b0;
                    end
                    count_next = count_next + 32'd1;
                    fin        = (count_next == nsz_next);
                end
                cnw_pkg::PH_PAD1:
                begin
                    if (off_next == 2'd0) begin
                        count_next = 32'd0;
                        phase_next = (fsz_next != 32'd0) ? cnw_pkg::PH_DATA
                                                          : cnw_pkg::PH_MAGIC;
                    end
                end
                cnw_pkg::PH_DATA:
                begin
                    count_next = count_next + 32'd1;
                    if (count_next == fsz_next) begin
                        count_next = 32'd0;
                        phase_next = (off_next != 2'd0) ? cnw_pkg::PH_PAD2
                                                         : cnw_pkg::PH_MAGIC;
                    end
                end
                default:
                begin
                    if (off_next == 2'd0) begin
                        phase_next = cnw_pkg::PH_MAGIC;
                        count_next = 32'd0;
                    end
                end
            endcase

            if (err) begin
                phase_next = cnw_pkg::PH_DONE;
                emit       = 1'b1;
                kind       = cnw_pkg::EV_ERROR;
            end
            else if (fin) begin
                emit = 1'b1;
                if (match_next && nsz_next >= cnw_pkg::TRL_LEN) begin
                    phase_next = cnw_pkg::PH_DONE;
                    kind       = cnw_pkg::EV_END;
                end
                else begin
                    kind       = cnw_pkg::EV_ENTRY;
                    count_next = 32'd0;
                    if (entries_next != COUNT_MAX) begin
                        entries_next = entries_next + COUNT_WIDTH'(1);
                    end
                    if (off_next != 2'd0) begin
                        phase_next = cnw_pkg::PH_PAD1;
                    end
                    else if (fsz_next != 32'd0) begin
                        phase_next = cnw_pkg::PH_DATA;
                    end
                    else begin
                        phase_next = cnw_pkg::PH_MAGIC;
                    end
                end
            end
        end
    end

    always_comb begin
        res.valid                = advance && emit;
        res.item.event_kind      = kind;
        res.item.entry_file_size = err ? 32'd0 : fsz_next;
        res.item.entry_name_size = err ? 32'd0 : nsz_next;
        res.item.files_seen      = 16'(entries_next);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg   <= cnw_pkg::PH_MAGIC;
            count_reg   <= 32'd0;
            nsz_reg     <= 32'd0;
            fsz_reg     <= 32'd0;
            match_reg   <= 1'b1;
            entries_reg <= '0;
            off_reg     <= 2'd0;
        end
        else if (advance) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            nsz_reg     <= nsz_next;
            fsz_reg     <= fsz_next;
            match_reg   <= match_next;
            entries_reg <= entries_next;
            off_reg     <= off_next;
        end
    end

    // An end or error event always leaves the walker stopped.
    a_stop_after_event: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && (kind == cnw_pkg::EV_END || kind == cnw_pkg::EV_ERROR))
        |=> phase_reg == cnw_pkg::PH_DONE)
        else $error("walker did not stop after end or error");

    // A stopped walker gives no event until a restart.
    a_silent_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == cnw_pkg::PH_DONE && !item_reg.restart) |-> !res.valid)
        else $error("event produced while stopped");

    // The entry count only grows between restarts.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item_reg.restart) |=> entries_reg >= $past(entries_reg))
        else $error("entry count went backwards");

endmodule

`default_nettype wire

### src/cnw_result_reg.sv
// ============================================================================
// cnw_result_reg
// Result register that holds one event item until the consumer takes it.
// ============================================================================
`default_nettype none

module cnw_result_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cnw_pkg::cnw_res_t    res,
    output logic                      res_ready,
    output logic                      event_valid,
    input  wire logic                 event_stall,
    output cnw_pkg::event_item_t      event_item
);

    logic                 valid_reg;
    cnw_pkg::event_item_t item_reg;

    assign res_ready   = !valid_reg || !event_stall;
    assign event_valid = valid_reg;
    assign event_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (res.valid) begin
            valid_reg <= 1'b1;
        end
        else if (!event_stall) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (res.valid) begin
            item_reg <= res.item;
        end
    end

    // A new result is only offered when the register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!valid_reg || !event_stall))
        else $error("result overwrote a waiting event");

    // Event kinds stay within the defined codes.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid |-> (event_item.event_kind == cnw_pkg::EV_ENTRY
                         || event_item.event_kind == cnw_pkg::EV_END
                         || event_item.event_kind == cnw_pkg::EV_ERROR))
        else $error("illegal event kind");

endmodule

`default_nettype wire

### src/cpio_newc_entry_walker_core.sv
// ============================================================================
// cpio_newc_entry_walker_core
// Walks a cpio newc archive byte by byte and reports each entry, the
// trailer, or a format error.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  byte      in         byte_valid / byte_stall    byte_item  (byte_item_t)
//  event     out        event_valid / event_stall  event_item (event_item_t)
//
//  One archive byte is taken every cycle when the output side is not stalled.
//  A byte passes the input register, the parser update and the result
//  register, in that order, before its event is offered.
//  Reset returns the walker to the start of an archive; restart does the same.
//  A stalled event holds the parser, and the stall reaches the byte side only
//  when the input register is also full.
//
`default_nettype none

module cpio_newc_entry_walker_core #(
    parameter int COUNT_WIDTH = cnw_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire cnw_pkg::byte_item_t  byte_item,
    output logic                      event_valid,
    input  wire logic                 event_stall,
    output cnw_pkg::event_item_t      event_item
);

    cnw_pkg::cnw_res_t res;
    logic              res_ready;

    cnw_parser #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .res_ready  (res_ready),
        .res        (res)
    );

    cnw_result_reg u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .res_ready   (res_ready),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_item  (event_item)
    );

endmodule

`default_nettype wire
